// File: hdl/acd_pkg.sv
// ---------------------------------------------------------------------------
// acd_pkg: shared types and codes for the digit matcher
// Request modes and result status codes.
// ---------------------------------------------------------------------------
package acd_pkg;

    typedef enum logic [2:0] {
        MODE_CLEAR   = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_END     = 3'd2,
        MODE_BUILD   = 3'd3,
        MODE_SCAN    = 3'd4,
        MODE_RESTART = 3'd5,
        MODE_NOP6    = 3'd6,
        MODE_NOP7    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_AFTER_BUILD  = 2'd2,
        ST_BEFORE_BUILD = 2'd3
    } t_status;

endpackage

// File: hdl/aho_corasick_digit_matcher.sv
// ---------------------------------------------------------------------------
// aho_corasick_digit_matcher: multi-pattern matcher over decimal digits
// Trie, failure links and match masks live in synchronous row memories.
// ---------------------------------------------------------------------------
// one request at a time; results leave through an output register
// build: breadth-first over a node queue, one goto row write-back per queued node
// reset: root row init in S_INIT after i_rst_n releases, then requests are taken
module aho_corasick_digit_matcher #(
    parameter int MAX_NODES    = 128,
    parameter int ALPHABET     = 10,
    parameter int MAX_PATTERNS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_mode,
    input  logic [3:0]            i_digit,
    input  logic [2:0]            i_pattern_id,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [6:0]            o_node,
    output logic [7:0]            o_node_matches,
    output logic [7:0]            o_seen_matches,
    output acd_pkg::t_status      o_status
);
    import acd_pkg::*;

    localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int CW = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int MW = MAX_PATTERNS;
    localparam int RW = ALPHABET * NW;

    typedef enum logic [17:0] {
        S_INIT = 18'd1 << 0,
        S_IDLE = 18'd1 << 1,
        S_INS1 = 18'd1 << 2,
        S_INS2 = 18'd1 << 3,
        S_SC1  = 18'd1 << 4,
        S_RD   = 18'd1 << 5,
        S_OUT  = 18'd1 << 6,
        S_BA0  = 18'd1 << 7,
        S_BAL  = 18'd1 << 8,
        S_BA   = 18'd1 << 9,
        S_BCHK = 18'd1 << 10,
        S_BQ   = 18'd1 << 11,
        S_BF   = 18'd1 << 12,
        S_BF2  = 18'd1 << 13,
        S_BF3  = 18'd1 << 14,
        S_BC   = 18'd1 << 15,
        S_BE1  = 18'd1 << 16,
        S_BE2  = 18'd1 << 17
    } t_state;

    t_state          r_state;
    logic [NW-1:0]   r_nc, r_cursor, r_scan, r_shown, r_u, r_v, r_new;
    logic [MW-1:0]   r_acc, r_emt;
    logic            r_built, r_clr_pend, r_acc_en, r_bw;
    t_status         r_status;
    logic [CW-1:0]   r_d, r_c;
    logic [NW:0]     r_head, r_tail;
    logic [RW-1:0]   r_row_u, r_row_f;

    // memories
    logic [RW-1:0]   mem_go [MAX_NODES];
    logic [NW-1:0]   mem_fl [MAX_NODES];
    logic [MW-1:0]   mem_em [MAX_NODES];
    logic [NW-1:0]   mem_q  [MAX_NODES];
    logic [RW-1:0]   r_go_rd;
    logic [NW-1:0]   r_fl_rd, r_q_rd;
    logic [MW-1:0]   r_em_rd;

    logic            go_we, em_we, fl_we, q_we;
    logic [NW-1:0]   go_waddr, go_raddr, em_waddr, em_raddr, fl_waddr, q_waddr;
    logic [RW-1:0]   go_wdata;
    logic [MW-1:0]   em_wdata;
    logic [NW-1:0]   fl_wdata, q_wdata;

    logic            accept, last_c, full;
    logic [CW-1:0]   d_sat;
    logic [NW-1:0]   ent, nxt, bv, bt;
    logic [MW-1:0]   pid_mask, n_acc;
    logic [NW+6:0]   node_ext;
    logic [MW+7:0]   em_ext, acc_ext;

    always_ff @(posedge i_clk) begin
        if (go_we) mem_go[go_waddr] <= go_wdata;
        r_go_rd <= mem_go[go_raddr];
        if (em_we) mem_em[em_waddr] <= em_wdata;
        r_em_rd <= mem_em[em_raddr];
        if (fl_we) mem_fl[fl_waddr] <= fl_wdata;
        r_fl_rd <= mem_fl[r_q_rd];
        if (q_we) mem_q[q_waddr] <= q_wdata;
        r_q_rd <= mem_q[r_head[NW-1:0]];
    end

    assign accept   = i_valid && (r_state == S_IDLE);
    assign o_ready  = (r_state == S_IDLE);
    assign d_sat    = (32'(i_digit) >= ALPHABET) ? CW'(ALPHABET - 1) : i_digit[CW-1:0];
    assign ent      = r_go_rd[r_d*NW +: NW];
    assign nxt      = r_nc + NW'(1);
    assign full     = (32'(r_nc) + 1) >= MAX_NODES;
    assign last_c   = (r_c == CW'(ALPHABET - 1));
    assign bv       = r_row_u[r_c*NW +: NW];
    assign bt       = r_row_f[r_c*NW +: NW];
    assign pid_mask = (32'(i_pattern_id) < MAX_PATTERNS) ? (MW'(1) << i_pattern_id) : '0;
    assign n_acc    = r_acc_en ? (r_acc | r_em_rd) : r_acc;

    // memory control
    always_comb begin
        go_we    = 1'b0;
        go_waddr = r_u;
        go_wdata = r_row_u;
        go_raddr = r_u;
        em_we    = 1'b0;
        em_waddr = r_cursor;
        em_wdata = '0;
        em_raddr = r_shown;
        fl_we    = 1'b0;
        fl_waddr = bv;
        fl_wdata = '0;
        q_we     = 1'b0;
        q_waddr  = r_tail[NW-1:0];
        q_wdata  = bv;
        unique case (r_state)
            S_INIT: begin
                go_we    = 1'b1;
                go_waddr = '0;
                go_wdata = '0;
                em_we    = 1'b1;
                em_waddr = '0;
            end
            S_IDLE: begin
                go_raddr = (t_mode'(i_mode) == MODE_SCAN) ? r_scan : r_cursor;
                if (accept && t_mode'(i_mode) == MODE_END && !r_built) begin
                    em_we    = 1'b1;
                    em_wdata = pid_mask;
                end
            end
            S_INS1: begin
                if (ent == '0 && !full) begin
                    go_we    = 1'b1;
                    go_waddr = r_cursor;
                    go_wdata = r_go_rd;
                    go_wdata[r_d*NW +: NW] = nxt;
                    em_we    = 1'b1;
                    em_waddr = nxt;
                end
            end
            S_INS2: begin
                go_we    = 1'b1;
                go_waddr = r_new;
                go_wdata = '0;
            end
            S_SC1, S_RD, S_OUT, S_BAL, S_BCHK, S_BQ, S_BF3: begin
            end
            S_BA0: go_raddr = '0;
            S_BA: begin
                if (bv != '0) begin
                    fl_we = 1'b1;
                    q_we  = (32'(r_tail) < MAX_NODES);
                end
            end
            S_BF: go_raddr = r_q_rd;
            S_BF2: go_raddr = r_fl_rd;
            S_BC: begin
                em_raddr = bt;
                if (r_bw) begin
                    go_we = 1'b1;
                end else if (bv != '0) begin
                    fl_we    = 1'b1;
                    fl_wdata = bt;
                    q_we     = (32'(r_tail) < MAX_NODES);
                end
            end
            S_BE1: em_raddr = r_v;
            S_BE2: begin
                em_we    = 1'b1;
                em_waddr = r_v;
                em_wdata = r_em_rd | r_emt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_nc       <= '0;
            r_cursor   <= '0;
            r_scan     <= '0;
            r_acc      <= '0;
            r_built    <= 1'b0;
            r_clr_pend <= 1'b0;
            r_acc_en   <= 1'b0;
            r_bw       <= 1'b0;
            r_status   <= ST_OK;
            r_shown    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_c        <= '0;
            o_valid    <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_state != S_OUT) o_valid <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_state    <= r_clr_pend ? S_RD : S_IDLE;
                    r_clr_pend <= 1'b0;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_d      <= d_sat;
                        r_status <= ST_OK;
                        r_acc_en <= 1'b0;
                        r_shown  <= r_scan;
                        r_state  <= S_RD;
                        unique case (t_mode'(i_mode))
                            MODE_CLEAR: begin
                                r_nc       <= '0;
                                r_cursor   <= '0;
                                r_scan     <= '0;
                                r_acc      <= '0;
                                r_built    <= 1'b0;
                                r_shown    <= '0;
                                r_clr_pend <= 1'b1;
                                r_state    <= S_INIT;
                            end
                            MODE_INSERT: begin
                                if (r_built) begin
                                    r_status <= ST_AFTER_BUILD;
                                    r_shown  <= r_cursor;
                                end else begin
                                    r_state <= S_INS1;
                                end
                            end
                            MODE_END: begin
                                r_shown <= r_cursor;
                                if (r_built) r_status <= ST_AFTER_BUILD;
                                else r_cursor <= '0;
                            end
                            MODE_BUILD: begin
                                r_shown <= '0;
                                if (!r_built) begin
                                    r_head  <= '0;
                                    r_tail  <= '0;
                                    r_state <= S_BA0;
                                end
                            end
                            MODE_SCAN: begin
                                if (!r_built) r_status <= ST_BEFORE_BUILD;
                                else r_state <= S_SC1;
                            end
                            MODE_RESTART: begin
                                r_scan  <= '0;
                                r_acc   <= '0;
                                r_shown <= '0;
                            end
                            MODE_NOP6, MODE_NOP7: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_INS1: begin
                    if (ent != '0) begin
                        r_cursor <= ent;
                        r_shown  <= ent;
                        r_state  <= S_RD;
                    end else if (full) begin
                        r_status <= ST_FULL;
                        r_shown  <= r_cursor;
                        r_state  <= S_RD;
                    end else begin
                        r_nc     <= nxt;
                        r_new    <= nxt;
                        r_cursor <= nxt;
                        r_shown  <= nxt;
                        r_state  <= S_INS2;
                    end
                end
                S_INS2: r_state <= S_RD;
                S_SC1: begin
                    r_scan   <= ent;
                    r_shown  <= ent;
                    r_acc_en <= 1'b1;
                    r_state  <= S_RD;
                end
                S_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_node         <= node_ext[6:0];
                        o_node_matches <= em_ext[7:0];
                        o_seen_matches <= acc_ext[7:0];
                        o_status       <= r_status;
                        r_acc          <= n_acc;
                        r_state        <= S_IDLE;
                    end
                end
                S_BA0: r_state <= S_BAL;
                S_BAL: begin
                    r_row_u <= r_go_rd;
                    r_c     <= '0;
                    r_state <= S_BA;
                end
                S_BA: begin
                    if (bv != '0 && 32'(r_tail) < MAX_NODES) r_tail <= r_tail + 1'b1;
                    r_c <= r_c + 1'b1;
                    if (last_c) r_state <= S_BCHK;
                end
                S_BCHK: begin
                    if (r_head < r_tail) begin
                        r_state <= S_BQ;
                    end else begin
                        r_built  <= 1'b1;
                        r_cursor <= '0;
                        r_scan   <= '0;
                        r_acc    <= '0;
                        r_shown  <= '0;
                        r_state  <= S_RD;
                    end
                end
                S_BQ: r_state <= S_BF;
                S_BF: begin
                    r_u     <= r_q_rd;
                    r_state <= S_BF2;
                end
                S_BF2: begin
                    r_row_u <= r_go_rd;
                    r_state <= S_BF3;
                end
                S_BF3: begin
                    r_row_f <= r_go_rd;
                    r_c     <= '0;
                    r_bw    <= 1'b0;
                    r_state <= S_BC;
                end
                S_BC: begin
                    // r_bw marks the goto row write-back pass after the last symbol
                    if (r_bw) begin
                        r_bw    <= 1'b0;
                        r_head  <= r_head + 1'b1;
                        r_state <= S_BCHK;
                    end else if (bv != '0) begin
                        r_v <= bv;
                        if (32'(r_tail) < MAX_NODES) r_tail <= r_tail + 1'b1;
                        r_state <= S_BE1;
                    end else begin
                        r_row_u[r_c*NW +: NW] <= bt;
                        if (last_c) r_bw <= 1'b1;
                        else r_c <= r_c + 1'b1;
                    end
                end
                S_BE1: begin
                    r_emt   <= r_em_rd;
                    r_state <= S_BE2;
                end
                S_BE2: begin
                    if (last_c) r_bw <= 1'b1;
                    else r_c <= r_c + 1'b1;
                    r_state <= S_BC;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign node_ext = {7'd0, r_shown};
    assign em_ext   = {8'd0, r_em_rd};
    assign acc_ext  = {8'd0, n_acc};

endmodule

// File: tb/sv/tb_aho_corasick_digit_matcher.sv
// ---------------------------------------------------------------------------
// tb_aho_corasick_digit_matcher: self-checking bench for the digit matcher
// Drives clear, insert, end, build, scan and restart requests through the
// valid/ready channel, predicts each result, and compares every field.
// ---------------------------------------------------------------------------
module tb_aho_corasick_digit_matcher;
    timeunit 1ns;
    timeprecision 1ps;
    import acd_pkg::*;

    localparam int NODES = 128;
    localparam int ALPH  = 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [6:0] node;
        logic [7:0] node_matches;
        logic [7:0] seen_matches;
        t_status    status;
    } t_match_result;

    typedef struct {
        t_mode         mode;
        logic [3:0]    digit;
        logic [2:0]    pid;
        bit            typed;
        t_match_result want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_mode = '0;
    logic [3:0] i_digit = '0;
    logic [2:0] i_pattern_id = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [6:0] o_node;
    logic [7:0] o_node_matches;
    logic [7:0] o_seen_matches;
    t_status    o_status;

    aho_corasick_digit_matcher uut (.*);

    always #6 i_clk = ~i_clk;

    // automaton copy used for prediction
    logic [6:0] trie_next [NODES*ALPH];
    logic [6:0] fail_of   [NODES];
    logic [7:0] pat_bits  [NODES];
    int         alloc_cnt;
    logic [6:0] ins_at;
    logic [6:0] scan_at;
    logic [7:0] seen_acc;
    bit         built;

    t_match_result pending_q [$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet_run = 0;
    bit  hold_off = 0;

    function automatic void wipe_trie();
        foreach (trie_next[k]) trie_next[k] = '0;
        foreach (fail_of[k]) fail_of[k] = '0;
        foreach (pat_bits[k]) pat_bits[k] = '0;
        alloc_cnt = 0;
        ins_at = '0;
        scan_at = '0;
        seen_acc = '0;
        built = 0;
    endfunction

    function automatic void link_failures();
        int order [$];
        int u, f, v, t;
        for (int c = 0; c < ALPH; c++) begin
            u = trie_next[c];
            if (u != 0) begin
                fail_of[u] = '0;
                order.push_back(u);
            end
        end
        while (order.size() > 0) begin
            u = order.pop_front();
            f = fail_of[u];
            for (int c = 0; c < ALPH; c++) begin
                v = trie_next[u*ALPH+c];
                t = trie_next[f*ALPH+c];
                if (v == 0) begin
                    trie_next[u*ALPH+c] = 7'(t);
                end else begin
                    fail_of[v] = 7'(t);
                    pat_bits[v] |= pat_bits[t];
                    order.push_back(v);
                end
            end
        end
    endfunction

    function automatic t_match_result step_matcher(t_mode m, logic [3:0] dg, logic [2:0] pid);
        t_match_result r;
        int d, nxt;
        logic [6:0] shown;
        d = (dg >= ALPH) ? ALPH - 1 : dg;
        shown = scan_at;
        r.status = ST_OK;
        case (m)
            MODE_CLEAR: begin
                wipe_trie();
                shown = '0;
            end
            MODE_INSERT: begin
                if (built) begin
                    r.status = ST_AFTER_BUILD;
                end else begin
                    nxt = trie_next[ins_at*ALPH+d];
                    if (nxt == 0) begin
                        if (alloc_cnt + 1 >= NODES) begin
                            r.status = ST_FULL;
                        end else begin
                            alloc_cnt++;
                            nxt = alloc_cnt;
                            for (int k = 0; k < ALPH; k++) trie_next[nxt*ALPH+k] = '0;
                            fail_of[nxt] = '0;
                            pat_bits[nxt] = '0;
                            trie_next[ins_at*ALPH+d] = 7'(nxt);
                        end
                    end
                    if (r.status == ST_OK) ins_at = 7'(nxt);
                end
                shown = ins_at;
            end
            MODE_END: begin
                shown = ins_at;
                if (built) begin
                    r.status = ST_AFTER_BUILD;
                end else begin
                    pat_bits[shown] = 8'(1) << pid;
                    ins_at = '0;
                end
            end
            MODE_BUILD: begin
                if (!built) begin
                    link_failures();
                    built = 1;
                    ins_at = '0;
                    scan_at = '0;
                    seen_acc = '0;
                end
                shown = '0;
            end
            MODE_SCAN: begin
                if (!built) begin
                    r.status = ST_BEFORE_BUILD;
                end else begin
                    scan_at = trie_next[scan_at*ALPH+d];
                    seen_acc |= pat_bits[scan_at];
                end
                shown = scan_at;
            end
            MODE_RESTART: begin
                scan_at = '0;
                seen_acc = '0;
                shown = '0;
            end
            default: ;
        endcase
        r.node = shown;
        r.node_matches = pat_bits[shown];
        r.seen_matches = seen_acc;
        return r;
    endfunction

    task automatic send_request(t_mode m, logic [3:0] dg, logic [2:0] pid);
        while (!quiet_run && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_digit <= dg;
        i_pattern_id <= pid;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_q.push_back(step_matcher(m, dg, pid));
    endtask

    // digits biased toward a small set so scans hit patterns
    function automatic logic [3:0] pick_digit();
        return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
    endfunction

    task automatic load_patterns(int npat, int maxlen);
        int len;
        for (int p = 0; p < npat; p++) begin
            len = $urandom_range(maxlen, 1);
            for (int k = 0; k < len; k++) send_request(MODE_INSERT, pick_digit(), 3'($urandom));
            send_request(MODE_END, pick_digit(), 3'($urandom));
        end
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_off) i_ready <= 1'b0;
        else i_ready <= quiet_run || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        t_match_result want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL aho_corasick_digit_matcher");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result exp none got node=%0d", $realtime, o_node);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_node !== want.node) begin
                    $display("%0t: node exp %0d got %0d", $realtime, want.node, o_node);
                    errors++;
                end
                if (o_node_matches !== want.node_matches) begin
                    $display("%0t: node_matches exp %h got %h", $realtime,
                             want.node_matches, o_node_matches);
                    errors++;
                end
                if (o_seen_matches !== want.seen_matches) begin
                    $display("%0t: seen_matches exp %h got %h", $realtime,
                             want.seen_matches, o_seen_matches);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    // typed expectations checked on top of the predictor
    t_row rows [$];

    function automatic t_row mk(t_mode m, logic [3:0] dg, logic [2:0] pid, bit ty,
                                logic [6:0] n, logic [7:0] nm, logic [7:0] sm, t_status st);
        t_row r;
        r.mode = m; r.digit = dg; r.pid = pid; r.typed = ty;
        r.want = '{n, nm, sm, st};
        return r;
    endfunction

    initial begin
        t_match_result got;
        wipe_trie();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        rows.push_back(mk(MODE_SCAN,    4'd3,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_BEFORE_BUILD));
        rows.push_back(mk(MODE_RESTART, 4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_NOP6,    4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd1,  3'd0, 1, 7'd1, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd2,  3'd0, 1, 7'd2, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_END,     4'd0,  3'd7, 1, 7'd2, 8'h80, 8'h00, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd2,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_END,     4'd0,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd15, 3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd9,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_END,     4'd0,  3'd5, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_BUILD,   4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_BUILD,   4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_INSERT,  4'd1,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_AFTER_BUILD));
        rows.push_back(mk(MODE_END,     4'd1,  3'd1, 1, 7'd0, 8'h00, 8'h00, ST_AFTER_BUILD));
        rows.push_back(mk(MODE_SCAN,    4'd1,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_SCAN,    4'd2,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_SCAN,    4'd2,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_SCAN,    4'd12, 3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_SCAN,    4'd9,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_NOP7,    4'd0,  3'd0, 0, '0, '0, '0, ST_OK));
        rows.push_back(mk(MODE_RESTART, 4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));
        rows.push_back(mk(MODE_CLEAR,   4'd0,  3'd0, 1, 7'd0, 8'h00, 8'h00, ST_OK));

        foreach (rows[i]) begin
            send_request(rows[i].mode, rows[i].digit, rows[i].pid);
            got = pending_q[$];
            if (rows[i].typed && got !== rows[i].want) begin
                $display("%0t: row %0d exp %h got %h", $realtime, i, rows[i].want, got);
                errors++;
            end
        end

        // fill the trie to the node limit with one long chain
        for (int k = 0; k < 135; k++) send_request(MODE_INSERT, 4'($urandom_range(9)), 3'd0);
        send_request(MODE_END, 4'd0, 3'd3);
        send_request(MODE_BUILD, 4'd0, 3'd0);
        for (int k = 0; k < 20; k++) send_request(MODE_SCAN, 4'($urandom_range(9)), 3'd0);
        send_request(MODE_CLEAR, 4'd0, 3'd0);

        // random sessions: load, build, scan stream, with some noise
        quiet_run = 0;
        for (int s = 0; s < 9; s++) begin
            if (s == 4) quiet_run = 1;
            if (s == 6) quiet_run = 0;
            if (s == 8) fork
                begin
                    hold_off = 1;
                    repeat (60) @(posedge i_clk);
                    hold_off = 0;
                end
            join_none
            load_patterns($urandom_range(6, 1), 4);
            if ($urandom_range(3) == 0) send_request(MODE_SCAN, pick_digit(), 3'd0);
            send_request(MODE_BUILD, 4'd0, 3'd0);
            for (int k = 0; k < 25; k++) begin
                case ($urandom_range(19))
                    0: send_request(MODE_RESTART, 4'($urandom), 3'($urandom));
                    1: send_request(t_mode'($urandom_range(7)), 4'($urandom), 3'($urandom));
                    default: send_request(MODE_SCAN, pick_digit(), 3'($urandom));
                endcase
            end
            send_request(MODE_CLEAR, 4'($urandom), 3'($urandom));
        end
        i_valid <= 1'b0;
        while (pending_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS aho_corasick_digit_matcher");
        end else begin
            $display("FAIL aho_corasick_digit_matcher");
        end
        $finish;
    end
endmodule
